// ===== design/vfrt_pkg.sv =====
// Shared types, constants and helpers of the video fragment reassembly tracker.
// Depends on nothing; every other design file imports it.
package vfrt_pkg;

  localparam int PEND_DEPTH   = 8;
  localparam int PARITY_DEPTH = 10;

  localparam int PIDX_W  = $clog2(PEND_DEPTH);
  localparam int PCNT_W  = $clog2(PEND_DEPTH + 1);
  localparam int PPTR_W  = (PARITY_DEPTH > 1) ? $clog2(PARITY_DEPTH) : 1;
  localparam int PPCNT_W = $clog2(PARITY_DEPTH + 1);

  localparam logic [3:0] EV_JOINED   = 4'd0;
  localparam logic [3:0] EV_MISMATCH = 4'd2;
  localparam logic [3:0] EV_OPENED   = 4'd1;
  localparam logic [3:0] EV_IDX_OVER = 4'd3;
  localparam logic [3:0] EV_LATE     = 4'd4;
  localparam logic [3:0] EV_IDX_BAD  = 4'd5;
  localparam logic [3:0] EV_CNT_BIG  = 4'd6;
  localparam logic [3:0] EV_DELIVER  = 4'd7;
  localparam logic [3:0] EV_DROP     = 4'd8;
  localparam logic [3:0] EV_FEC_REL  = 4'd9;
  localparam logic [3:0] EV_FEC_STO  = 4'd10;

  localparam logic [31:0] SEQ_HI_MASK = 32'hFFFFFF00;
  localparam logic [31:0] SEQ_WRAP    = 32'd256;
  localparam logic [7:0]  GOT_MAX     = 8'd255;

  localparam logic [2:0] REG_HOLD_LIMIT  = 3'd0;
  localparam logic [2:0] REG_LATE_WINDOW = 3'd4;

  typedef logic [PIDX_W-1:0]  pidx_t;
  typedef logic [PCNT_W-1:0]  pcnt_t;
  typedef logic [PPTR_W-1:0]  ppos_t;
  typedef logic [PPCNT_W-1:0] ppcnt_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] stamp;
    logic [7:0]  total;
    logic [7:0]  got;
    logic        key;
    logic [15:0] turn;
  } pend_entry_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic        inc;
    pend_entry_t entry;
  } pend_cmd_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [7:0]  span;
  } par_entry_t;

  // True when a parity record ending at pseq and spanning pspan frames covers seq.
  function automatic logic covers(logic [31:0] seq, logic [31:0] pseq, logic [7:0] pspan);
    logic [31:0] low_end;
    low_end = pseq - {24'd0, pspan};
    return (seq <= pseq) && (seq > low_end);
  endfunction

endpackage

// ===== design/vfrt_pend_table.sv =====
// Pending frame table: a ring of entries in flip-flops, oldest at the head.
// Depends on vfrt_pkg.
module vfrt_pend_table (
  input  logic                clk,
  input  logic                rst_n,
  input  vfrt_pkg::pend_cmd_t cmd,
  input  vfrt_pkg::pidx_t     rd_off,
  output vfrt_pkg::pend_entry_t rd_data,
  output vfrt_pkg::pcnt_t     used
);
  import vfrt_pkg::*;

  pend_entry_t ent_r [PEND_DEPTH];
  pidx_t       head_r, head_nxt;
  pcnt_t       used_r, used_nxt;
  pidx_t       rd_idx, wr_idx;

  function automatic pidx_t wrap_add(pidx_t a, pidx_t b);
    logic [PIDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (PIDX_W + 1)'(PEND_DEPTH)) begin
      s = s - (PIDX_W + 1)'(PEND_DEPTH);
    end
    return s[PIDX_W-1:0];
  endfunction

  assign rd_idx  = wrap_add(head_r, rd_off);
  assign wr_idx  = wrap_add(head_r, used_r[PIDX_W-1:0]);
  assign rd_data = ent_r[rd_idx];
  assign used    = used_r;

  always_comb begin
    head_nxt = head_r;
    used_nxt = used_r;
    if (cmd.pop && (used_r != '0)) begin
      head_nxt = wrap_add(head_r, pidx_t'(1));
      used_nxt = used_r - pcnt_t'(1);
    end else if (cmd.push && (used_r < pcnt_t'(PEND_DEPTH))) begin
      used_nxt = used_r + pcnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      used_r <= '0;
    end else begin
      head_r <= head_nxt;
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && (used_r < pcnt_t'(PEND_DEPTH))) begin
      ent_r[wr_idx] <= cmd.entry;
    end else if (cmd.inc && (ent_r[rd_idx].got < GOT_MAX)) begin
      ent_r[rd_idx].got <= ent_r[rd_idx].got + 8'd1;
    end
  end

endmodule

// ===== design/vfrt_par_ring.sv =====
// Parity record ring; when full a new record replaces the oldest one.
// Depends on vfrt_pkg.
module vfrt_par_ring (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  vfrt_pkg::par_entry_t wr_data,
  input  vfrt_pkg::ppos_t      rd_off,
  output vfrt_pkg::par_entry_t rd_data,
  output vfrt_pkg::ppcnt_t     used
);
  import vfrt_pkg::*;

  par_entry_t rec_r [PARITY_DEPTH];
  ppos_t      head_r;
  ppcnt_t     used_r;
  ppos_t      rd_idx, wr_idx;
  logic       full;

  function automatic ppos_t wrap_add(ppos_t a, ppos_t b);
    logic [PPTR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (PPTR_W + 1)'(PARITY_DEPTH)) begin
      s = s - (PPTR_W + 1)'(PARITY_DEPTH);
    end
    return s[PPTR_W-1:0];
  endfunction

  assign full    = (used_r == ppcnt_t'(PARITY_DEPTH));
  assign rd_idx  = wrap_add(head_r, rd_off);
  assign wr_idx  = full ? head_r : wrap_add(head_r, used_r[PPTR_W-1:0]);
  assign rd_data = rec_r[rd_idx];
  assign used    = used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      used_r <= '0;
    end else if (wr_en) begin
      if (full) begin
        head_r <= wrap_add(head_r, ppos_t'(1));
      end else begin
        used_r <= used_r + ppcnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rec_r[wr_idx] <= wr_data;
    end
  end

endmodule

// ===== design/video_fragment_reassembly_tracker.sv =====
// Top level of the video fragment reassembly tracker: sequencer, registers, output.
// Depends on vfrt_pkg, vfrt_pend_table and vfrt_par_ring.
//
// An item is taken when start is high and busy is low. Busy stays high until the
// item's final result has been decided, and that result is on the outputs in the
// first cycle in which busy is low. A fragment walks the pending table one entry
// per cycle looking for its stamp. Each retirement check of the oldest frame walks
// the parity ring one record per cycle through one shared coverage comparator.
// A fragment that matches a pending entry ends its search there. A fragment
// that opens a new frame then retires pending frames from the oldest: each is
// delivered, dropped or released against a parity record, and a parity search
// that finds nothing ends the item. A parity item may release the oldest frame
// and then stores its record. Each result is presented on out_valid for one
// cycle, when the item's next result is decided or when the item ends, so that
// the final one can carry out_last. The receiver cannot hold results off and
// must take them as they come.
module video_fragment_reassembly_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [31:0] in_stamp,
  input  logic [7:0]  in_seq_low,
  input  logic [15:0] in_part_index,
  input  logic [15:0] in_part_total,
  input  logic        in_is_key,
  input  logic [15:0] in_turn,
  input  logic [7:0]  in_span,
  output logic        out_valid,
  output logic [3:0]  out_event_res,
  output logic [31:0] out_frame_seq,
  output logic        out_frame_key,
  output logic [15:0] out_frame_turn,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vfrt_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRCH  = 4'd1;
  localparam logic [3:0] S_EXT   = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_RHEAD = 4'd4;
  localparam logic [3:0] S_RPAR  = 4'd5;
  localparam logic [3:0] S_PCHK  = 4'd6;
  localparam logic [3:0] S_PWR   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]  state_r, state_nxt;
  logic [2:0]  hold_limit_r;
  logic [7:0]  late_window_r;
  logic [31:0] last_seq_r, last_seq_nxt;
  logic        await_r, await_nxt;
  pcnt_t       cnt_r, cnt_nxt;
  ppcnt_t      pcnt_r, pcnt_nxt;
  logic [31:0] fseq_r, fseq_nxt;

  logic        kind_r, key_r;
  logic [31:0] stamp_r;
  logic [7:0]  low_r, span_r;
  logic [15:0] idx_r, tot_r, turn_r;

  pend_cmd_t   pcmd;
  pend_entry_t prd;
  pcnt_t       pused;
  pidx_t       prd_off;
  logic        par_wr;
  par_entry_t  par_wdata, par_rd;
  ppcnt_t      par_used;

  logic        emit_v, fin;
  logic [3:0]  emit_ev;
  logic [31:0] emit_seq;
  logic        emit_key;
  logic [15:0] emit_turn;

  logic        hold_v_r;
  logic [3:0]  hold_ev_r;
  logic [31:0] hold_seq_r;
  logic        hold_key_r;
  logic [15:0] hold_turn_r;

  logic        out_valid_r, out_key_r, out_last_r;
  logic [3:0]  out_ev_r;
  logic [31:0] out_seq_r;
  logic [15:0] out_turn_r;

  logic [31:0] pseq_c, cov_pseq;
  logic [7:0]  cov_span;
  logic        cov_hit;
  pcnt_t       lim;
  logic        accept, cfg_wr;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr)
      REG_HOLD_LIMIT:  prdata = {29'd0, hold_limit_r};
      REG_LATE_WINDOW: prdata = {24'd0, late_window_r};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_limit_r  <= 3'd3;
      late_window_r <= 8'd3;
    end else if (cfg_wr) begin
      if (paddr == REG_HOLD_LIMIT) begin
        hold_limit_r <= pwdata[2:0];
      end else if (paddr == REG_LATE_WINDOW) begin
        late_window_r <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (hold_limit_r == 3'd0) begin
      lim = pcnt_t'(1);
    end else if (32'(hold_limit_r) > 32'(PEND_DEPTH - 2)) begin
      lim = pcnt_t'(PEND_DEPTH - 2);
    end else begin
      lim = pcnt_t'(hold_limit_r);
    end
  end

  vfrt_pend_table u_pend (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (pcmd),
    .rd_off  (prd_off),
    .rd_data (prd),
    .used    (pused)
  );

  vfrt_par_ring u_par (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (par_wr),
    .wr_data (par_wdata),
    .rd_off  (pcnt_r[PPTR_W-1:0]),
    .rd_data (par_rd),
    .used    (par_used)
  );

  // Parity items extend their sequence without stepping ahead a wrap.
  assign pseq_c   = (last_seq_r & SEQ_HI_MASK) | {24'd0, low_r};
  assign prd_off  = (state_r == S_SRCH) ? cnt_r[PIDX_W-1:0] : '0;
  assign cov_pseq = (state_r == S_RPAR) ? par_rd.seq : pseq_c;
  assign cov_span = (state_r == S_RPAR) ? par_rd.span : span_r;
  assign cov_hit  = covers(prd.seq, cov_pseq, cov_span);

  assign par_wdata.seq  = pseq_c;
  assign par_wdata.span = span_r;

  always_comb begin
    state_nxt    = state_r;
    last_seq_nxt = last_seq_r;
    await_nxt    = await_r;
    cnt_nxt      = cnt_r;
    pcnt_nxt     = pcnt_r;
    fseq_nxt     = fseq_r;
    pcmd         = '0;
    par_wr       = 1'b0;
    emit_v       = 1'b0;
    emit_ev      = EV_JOINED;
    emit_seq     = fseq_r;
    emit_key     = 1'b0;
    emit_turn    = 16'd0;
    fin          = 1'b0;

    pcmd.entry.seq   = fseq_r;
    pcmd.entry.stamp = stamp_r;
    pcmd.entry.total = tot_r[7:0];
    pcmd.entry.got   = 8'd1;
    pcmd.entry.key   = key_r;
    pcmd.entry.turn  = turn_r;

    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          state_nxt = in_kind ? S_PCHK : S_SRCH;
        end
      end
      S_SRCH: begin
        if (cnt_r < pused) begin
          if (prd.stamp == stamp_r) begin
            emit_v   = 1'b1;
            emit_seq = prd.seq;
            if (tot_r != {8'd0, prd.total}) begin
              emit_ev = EV_MISMATCH;
            end else if (idx_r >= {8'd0, prd.total}) begin
              emit_ev = EV_IDX_OVER;
            end else begin
              emit_ev  = EV_JOINED;
              pcmd.inc = 1'b1;
            end
            state_nxt = S_FIN;
          end else begin
            cnt_nxt = cnt_r + pcnt_t'(1);
          end
        end else begin
          state_nxt = S_EXT;
        end
      end
      S_EXT: begin
        fseq_nxt = (last_seq_r & SEQ_HI_MASK) | {24'd0, low_r};
        if (last_seq_r[7:0] > low_r) begin
          fseq_nxt = fseq_nxt + SEQ_WRAP;
        end
        state_nxt = S_CHK;
      end
      S_CHK: begin
        emit_v = 1'b1;
        if ((last_seq_r > {24'd0, late_window_r}) &&
            (fseq_r < last_seq_r - {24'd0, late_window_r})) begin
          emit_ev   = EV_LATE;
          state_nxt = S_FIN;
        end else if (idx_r >= tot_r) begin
          emit_ev   = EV_IDX_BAD;
          state_nxt = S_FIN;
        end else if (tot_r > 16'd255) begin
          emit_ev   = EV_CNT_BIG;
          state_nxt = S_FIN;
        end else begin
          emit_ev      = EV_OPENED;
          pcmd.push    = 1'b1;
          last_seq_nxt = fseq_r;
          state_nxt    = S_RHEAD;
        end
      end
      S_RHEAD: begin
        emit_seq  = prd.seq;
        emit_key  = prd.key;
        emit_turn = prd.turn;
        pcnt_nxt  = '0;
        if (pused > lim) begin
          if (prd.got == prd.total) begin
            emit_v   = 1'b1;
            emit_ev  = EV_DELIVER;
            pcmd.pop = 1'b1;
          end else if (({1'b0, prd.got} + 9'd1 == {1'b0, prd.total}) && !await_r) begin
            state_nxt = S_RPAR;
          end else begin
            await_nxt = 1'b0;
            emit_v    = 1'b1;
            emit_ev   = EV_DROP;
            pcmd.pop  = 1'b1;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_RPAR: begin
        emit_seq  = prd.seq;
        emit_key  = prd.key;
        emit_turn = prd.turn;
        if (pcnt_r < par_used) begin
          if (cov_hit) begin
            emit_v    = 1'b1;
            emit_ev   = EV_FEC_REL;
            pcmd.pop  = 1'b1;
            state_nxt = S_RHEAD;
          end else begin
            pcnt_nxt = pcnt_r + ppcnt_t'(1);
          end
        end else begin
          await_nxt = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_PCHK: begin
        emit_seq  = prd.seq;
        emit_key  = prd.key;
        emit_turn = prd.turn;
        if (await_r && (pused != '0) && cov_hit) begin
          emit_v    = 1'b1;
          emit_ev   = EV_FEC_REL;
          pcmd.pop  = 1'b1;
          await_nxt = 1'b0;
        end
        state_nxt = S_PWR;
      end
      S_PWR: begin
        par_wr    = 1'b1;
        emit_v    = 1'b1;
        emit_ev   = EV_FEC_STO;
        emit_seq  = pseq_c;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      last_seq_r <= 32'd0;
      await_r    <= 1'b0;
      cnt_r      <= '0;
      pcnt_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      last_seq_r <= last_seq_nxt;
      await_r    <= await_nxt;
      cnt_r      <= cnt_nxt;
      pcnt_r     <= pcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fseq_r <= fseq_nxt;
    if (accept) begin
      kind_r  <= in_kind;
      stamp_r <= in_stamp;
      low_r   <= in_seq_low;
      idx_r   <= in_part_index;
      tot_r   <= in_part_total;
      key_r   <= in_is_key;
      turn_r  <= in_turn;
      span_r  <= in_span;
    end
  end

  // A result is held back one step so that the final one can carry last.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (emit_v || fin) && hold_v_r;
      if (emit_v) begin
        hold_v_r <= 1'b1;
      end else if (fin) begin
        hold_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_v || fin) begin
      out_ev_r   <= hold_ev_r;
      out_seq_r  <= hold_seq_r;
      out_key_r  <= hold_key_r;
      out_turn_r <= hold_turn_r;
      out_last_r <= fin;
    end
    if (emit_v) begin
      hold_ev_r   <= emit_ev;
      hold_seq_r  <= emit_seq;
      hold_key_r  <= emit_key;
      hold_turn_r <= emit_turn;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_res  = out_ev_r;
  assign out_frame_seq  = out_seq_r;
  assign out_frame_key  = out_key_r;
  assign out_frame_turn = out_turn_r;
  assign out_last       = out_last_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pused <= pcnt_t'(PEND_DEPTH))
    else $error("pending count beyond table depth");

  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without an item in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after a transfer");

  a_par_write_kind: assert property (@(posedge clk) disable iff (!rst_n)
    par_wr |-> kind_r)
    else $error("parity ring written by a video fragment");

endmodule
